// ===== hw/rtl/hizq_pkg.sv =====
// Shared types and constants of the hierarchical-Z tile occlusion query.
// Holds the command kinds, the register map, the configuration and result words.
// No dependencies.
package hizq_pkg;

    // fixed field widths of the item and register ports
    localparam int COORD_W = 16;
    localparam int PIX_W   = 12;
    localparam int ORG_W   = 11;
    localparam int TCOL_W  = 7;
    localparam int TROW_W  = 9;
    localparam int WROW_W  = 8;
    localparam int WCOL_W  = 6;
    localparam int KIND_W  = 2;
    localparam int LANES   = 4;

    typedef enum logic [KIND_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_SKIP  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_FIRST_X       = 3'd2,
        REG_FIRST_Y       = 3'd3,
        REG_LAST_X        = 3'd4,
        REG_LAST_Y        = 3'd5,
        REG_TILE_COLUMNS  = 3'd6,
        REG_TILE_ROWS     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]  screen_width;
        logic [PIX_W-1:0]  screen_height;
        logic [ORG_W-1:0]  first_x;
        logic [ORG_W-1:0]  first_y;
        logic [ORG_W-1:0]  last_x;
        logic [ORG_W-1:0]  last_y;
        logic [TCOL_W-1:0] tile_columns;
        logic [TROW_W-1:0] tile_rows;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        screen_width:  12'd2048,
        screen_height: 12'd2048,
        first_x:       11'd0,
        first_y:       11'd0,
        last_x:        11'd2016,
        last_y:        11'd2040,
        tile_columns:  7'd64,
        tile_rows:     9'd256
    };

    typedef struct packed {
        logic tested;
        logic now_culled;
    } t_result;

endpackage

// ===== hw/rtl/hizq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the per-tile maximum depth store. No dependencies.
module hizq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hizq_fifo.sv =====
// Short register queue used between the front and the back and on the result side.
// No dependencies.
module hizq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/hizq_front.sv =====
// Front end: accepts words, classifies them and turns a query box into a tile range.
// Depends on hizq_pkg.
module hizq_front #(
    parameter int TILE_WIDTH = 32,
    parameter int TILE_HEIGHT = 8,
    parameter int MAX_TILE_COLUMNS = 64,
    parameter int MAX_TILE_ROWS = 256,
    parameter int DEPTH_BITS = 24,
    localparam int CW = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1,
    localparam int RW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1,
    localparam int CMD_W = hizq_pkg::KIND_W + DEPTH_BITS + 2 * RW + 2 * CW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_action,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_min_x,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_min_y,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_max_x,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_max_y,
    input  logic signed [DEPTH_BITS-1:0]        i_nearest_depth,
    input  logic                                i_already_culled,
    input  logic                                i_all_w_positive,
    input  logic [hizq_pkg::WROW_W-1:0]         i_tile_row,
    input  logic [hizq_pkg::WCOL_W-1:0]         i_tile_col,
    input  logic signed [DEPTH_BITS-1:0]        i_tile_depth,
    input  hizq_pkg::t_cfg                      i_cfg,
    output logic                                o_cmd_push,
    output logic [CMD_W-1:0]                    o_cmd_data,
    input  logic                                i_cmd_full
);
    import hizq_pkg::*;

    // Exact division of a 12-bit value by a tile size: multiply by a rounded-up
    // reciprocal and shift.
    localparam int SHX = PIX_W + $clog2(TILE_WIDTH);
    localparam int SHY = PIX_W + $clog2(TILE_HEIGHT);
    localparam int RCX = ((1 << SHX) + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int RCY = ((1 << SHY) + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int RECIP [LANES] = '{RCX, RCY, RCX, RCY};
    localparam int SHIFT [LANES] = '{SHX, SHY, SHX, SHY};
    localparam int TILE  [LANES] = '{TILE_WIDTH, TILE_HEIGHT, TILE_WIDTH, TILE_HEIGHT};

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_CLAMP = 6'b000010,
        F_DIV1  = 6'b000100,
        F_ORG   = 6'b001000,
        F_DIV2  = 6'b010000,
        F_PUSH  = 6'b100000
    } t_fstate;

    t_fstate                      r_state;
    t_fstate                      n_state;
    logic [COORD_W-1:0]           r_raw [LANES];
    logic [PIX_W-1:0]             r_val [LANES];
    t_cmd_kind                    r_kind;
    logic signed [DEPTH_BITS-1:0] r_depth;
    logic [CW-1:0]                r_sx;
    logic [CW-1:0]                r_ex;
    logic [RW-1:0]                r_sy;
    logic [RW-1:0]                r_ey;

    logic [PIX_W-1:0] w_lim   [LANES];
    logic [PIX_W-1:0] w_first [LANES];
    logic [PIX_W-1:0] w_last  [LANES];
    logic [PIX_W-1:0] w_clamp [LANES];
    logic [31:0]      w_prod  [LANES];
    logic [PIX_W-1:0] w_quot  [LANES];
    logic [PIX_W-1:0] w_snap  [LANES];
    logic [PIX_W-1:0] w_bound [LANES];
    logic [PIX_W-1:0] w_org   [LANES];
    logic [10:0]      w_cols;
    logic [10:0]      w_rows;
    logic [CW-1:0]    w_cols_m1;
    logic [RW-1:0]    w_rows_m1;
    logic             w_skip;
    logic             w_wr_ok;

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_PUSH);
    assign o_cmd_data = {r_kind, r_depth, r_ey, r_sy, r_ex, r_sx};
    assign w_skip     = i_already_culled || !i_all_w_positive;
    assign w_wr_ok    = ({3'b000, i_tile_row} < 11'(MAX_TILE_ROWS))
                     && ({5'b00000, i_tile_col} < 11'(MAX_TILE_COLUMNS));

    // grid in use, saturated to 1..MAX
    always_comb begin
        w_cols = (i_cfg.tile_columns == '0) ? 11'd1 : 11'(i_cfg.tile_columns);
        if (w_cols > 11'(MAX_TILE_COLUMNS)) begin
            w_cols = 11'(MAX_TILE_COLUMNS);
        end
        w_rows = (i_cfg.tile_rows == '0) ? 11'd1 : 11'(i_cfg.tile_rows);
        if (w_rows > 11'(MAX_TILE_ROWS)) begin
            w_rows = 11'(MAX_TILE_ROWS);
        end
        w_cols_m1 = CW'(w_cols - 11'd1);
        w_rows_m1 = RW'(w_rows - 11'd1);
    end

    // per-lane datapath: lanes are min x, min y, max x, max y
    always_comb begin
        w_lim[0]   = i_cfg.screen_width;
        w_lim[1]   = i_cfg.screen_height;
        w_lim[2]   = i_cfg.screen_width;
        w_lim[3]   = i_cfg.screen_height;
        w_first[0] = {1'b0, i_cfg.first_x};
        w_first[1] = {1'b0, i_cfg.first_y};
        w_first[2] = {1'b0, i_cfg.first_x};
        w_first[3] = {1'b0, i_cfg.first_y};
        w_last[0]  = {1'b0, i_cfg.last_x};
        w_last[1]  = {1'b0, i_cfg.last_y};
        w_last[2]  = {1'b0, i_cfg.last_x};
        w_last[3]  = {1'b0, i_cfg.last_y};
        for (int i = 0; i < LANES; i++) begin
            // clamp to [0, screen size]
            if (r_raw[i][COORD_W-1]) begin
                w_clamp[i] = '0;
            end else if (r_raw[i][COORD_W-2:0] > {3'b000, w_lim[i]}) begin
                w_clamp[i] = w_lim[i];
            end else begin
                w_clamp[i] = r_raw[i][PIX_W-1:0];
            end
            // one divider per lane, used for both the snap and the index
            w_prod[i] = 32'(r_val[i]) * 32'(RECIP[i]);
            w_quot[i] = PIX_W'(w_prod[i] >> SHIFT[i]);
            // snap down to the tile origin, then clamp to the origin range
            w_snap[i] = r_val[i] * PIX_W'(TILE[i]);
            if (i < 2) begin
                w_bound[i] = (w_snap[i] < w_first[i]) ? w_first[i] : w_snap[i];
                w_org[i]   = (w_bound[i] > w_last[i]) ? w_last[i] : w_bound[i];
            end else begin
                w_bound[i] = (w_snap[i] > w_last[i]) ? w_last[i] : w_snap[i];
                w_org[i]   = (w_bound[i] < w_first[i]) ? w_first[i] : w_bound[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    if (i_action) begin
                        n_state = w_wr_ok ? F_PUSH : F_IDLE;
                    end else if (w_skip) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_CLAMP;
                    end
                end
            end
            F_CLAMP: n_state = F_DIV1;
            F_DIV1:  n_state = F_ORG;
            F_ORG:   n_state = F_DIV2;
            F_DIV2:  n_state = F_PUSH;
            F_PUSH:  n_state = i_cmd_full ? F_PUSH : F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_raw[0] <= i_box_min_x;
                r_raw[1] <= i_box_min_y;
                r_raw[2] <= i_box_max_x;
                r_raw[3] <= i_box_max_y;
                r_depth  <= i_action ? i_tile_depth : i_nearest_depth;
                r_sx     <= CW'(i_tile_col);
                r_sy     <= RW'(i_tile_row);
                if (i_action) begin
                    r_kind <= CMD_WRITE;
                end else if (w_skip) begin
                    r_kind <= CMD_SKIP;
                end else begin
                    r_kind <= CMD_QUERY;
                end
            end
            F_CLAMP: r_val <= w_clamp;
            F_DIV1:  r_val <= w_quot;
            F_ORG:   r_val <= w_org;
            F_DIV2: begin
                // limit the tile indexes to the grid
                r_sx <= (w_quot[0] > PIX_W'(w_cols_m1)) ? w_cols_m1 : CW'(w_quot[0]);
                r_sy <= (w_quot[1] > PIX_W'(w_rows_m1)) ? w_rows_m1 : RW'(w_quot[1]);
                r_ex <= (w_quot[2] > PIX_W'(w_cols_m1)) ? w_cols_m1 : CW'(w_quot[2]);
                r_ey <= (w_quot[3] > PIX_W'(w_rows_m1)) ? w_rows_m1 : RW'(w_quot[3]);
            end
            F_PUSH: begin
                r_kind <= r_kind;
            end
            default: begin
                r_kind <= r_kind;
            end
        endcase
    end

endmodule

// ===== hw/rtl/hizq_back.sv =====
// Back end: applies tile writes and walks the tile range of a query, one RAM read a cycle.
// Depends on hizq_pkg and hizq_ram.
module hizq_back #(
    parameter int MAX_TILE_COLUMNS = 64,
    parameter int MAX_TILE_ROWS = 256,
    parameter int DEPTH_BITS = 24,
    localparam int CW = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1,
    localparam int RW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1,
    localparam int CMD_W = hizq_pkg::KIND_W + DEPTH_BITS + 2 * RW + 2 * CW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  logic [CMD_W-1:0]  i_cmd_data,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output hizq_pkg::t_result o_res_data
);
    import hizq_pkg::*;

    localparam int TILES = MAX_TILE_ROWS * MAX_TILE_COLUMNS;
    localparam int AW = (TILES > 1) ? $clog2(TILES) : 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_WALK = 3'b010,
        B_LAST = 3'b100
    } t_bstate;

    t_bstate                      r_state;
    t_bstate                      n_state;
    logic [CW-1:0]                r_x;
    logic [CW-1:0]                r_sx;
    logic [CW-1:0]                r_ex;
    logic [RW-1:0]                r_y;
    logic [RW-1:0]                r_ey;
    logic signed [DEPTH_BITS-1:0] r_near;
    logic                         r_pend;

    t_cmd_kind                    w_kind;
    logic [CW-1:0]                w_sx;
    logic [CW-1:0]                w_ex;
    logic [RW-1:0]                w_sy;
    logic [RW-1:0]                w_ey;
    logic signed [DEPTH_BITS-1:0] w_depth;
    logic                         w_take;
    logic                         w_we;
    logic                         w_re;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic [DEPTH_BITS-1:0]        w_rdata;
    logic                         w_hit;
    logic                         w_last_tile;

    assign w_sx    = i_cmd_data[CW-1:0];
    assign w_ex    = i_cmd_data[2*CW-1:CW];
    assign w_sy    = i_cmd_data[2*CW +: RW];
    assign w_ey    = i_cmd_data[2*CW+RW +: RW];
    assign w_depth = i_cmd_data[2*CW+2*RW +: DEPTH_BITS];
    assign w_kind  = t_cmd_kind'(i_cmd_data[CMD_W-1 -: KIND_W]);

    assign w_take      = (r_state == B_IDLE) && !i_cmd_empty && !i_res_full;
    assign o_cmd_pop   = w_take;
    assign w_waddr     = AW'(w_sy) * AW'(MAX_TILE_COLUMNS) + AW'(w_sx);
    assign w_raddr     = AW'(r_y) * AW'(MAX_TILE_COLUMNS) + AW'(r_x);
    assign w_hit       = r_pend && (r_near < $signed(w_rdata));
    assign w_last_tile = (r_x == r_ex) && (r_y == r_ey);

    hizq_ram #(
        .WIDTH(DEPTH_BITS),
        .DEPTH(TILES)
    ) u_tile_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_depth),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        o_res_push = 1'b0;
        o_res_data = '{tested: 1'b1, now_culled: 1'b1};
        w_we       = 1'b0;
        w_re       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (w_take) begin
                    unique case (w_kind)
                        CMD_WRITE: w_we = 1'b1;
                        CMD_SKIP: begin
                            o_res_push = 1'b1;
                            o_res_data = '{tested: 1'b0, now_culled: 1'b0};
                        end
                        CMD_QUERY: begin
                            // crossed range: nothing to walk, cull
                            if ((w_sx > w_ex) || (w_sy > w_ey)) begin
                                o_res_push = 1'b1;
                            end else begin
                                n_state = B_WALK;
                            end
                        end
                        default: w_we = 1'b0;
                    endcase
                end
            end
            B_WALK: begin
                if (w_hit) begin
                    o_res_push = 1'b1;
                    o_res_data = '{tested: 1'b1, now_culled: 1'b0};
                    n_state    = B_IDLE;
                end else begin
                    w_re = 1'b1;
                    if (w_last_tile) begin
                        n_state = B_LAST;
                    end
                end
            end
            B_LAST: begin
                o_res_push = 1'b1;
                o_res_data = '{tested: 1'b1, now_culled: !w_hit};
                n_state    = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x    <= w_sx;
            r_sx   <= w_sx;
            r_ex   <= w_ex;
            r_y    <= w_sy;
            r_ey   <= w_ey;
            r_near <= w_depth;
        end else if (w_re) begin
            // advance row by row
            if (r_x == r_ex) begin
                r_x <= r_sx;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hiz_tile_occlusion_query.sv =====
// Top level of the hierarchical-Z tile occlusion query: register file, queues, front, back.
// Depends on hizq_pkg, hizq_front, hizq_fifo and hizq_back.
//
//   channel   handshake            word
//   -------   ------------------   ---------------------------------------------
//   input     push / full          action, box corners, depths, flags, tile pos
//   result    pop / empty          tested, now_culled
//   config    psel/penable/pready  8 registers at byte address 4*i, 32-bit data
//
// The front takes a query word through clamp, divide, snap and origin clamp, divide
// and grid limit, and hand-off; a tile write or a skipped query goes straight to hand-off.
// The back handles a write, a skip or an empty walk straight from idle and walks the
// tiles of any other query; the single read port of the tile RAM sets one tile per
// cycle, and the walk stops at the first tile that is farther than the box.
// A two-word queue sits between front and back and another ahead of the result
// ports, so either side can stall without holding up the other until the queues fill.
// Reset (synchronous) loads the register defaults and empties both queues; the
// tile store is not cleared, so a query must only cover tiles written since.
module hiz_tile_occlusion_query #(
    parameter int TILE_WIDTH = 32,
    parameter int TILE_HEIGHT = 8,
    parameter int MAX_TILE_COLUMNS = 64,
    parameter int MAX_TILE_ROWS = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input queue side
    input  logic                                push,
    output logic                                full,
    input  logic                                i_action,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_min_x,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_min_y,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_max_x,
    input  logic signed [hizq_pkg::COORD_W-1:0] i_box_max_y,
    input  logic signed [DEPTH_BITS-1:0]        i_nearest_depth,
    input  logic                                i_already_culled,
    input  logic                                i_all_w_positive,
    input  logic [hizq_pkg::WROW_W-1:0]         i_tile_row,
    input  logic [hizq_pkg::WCOL_W-1:0]         i_tile_col,
    input  logic signed [DEPTH_BITS-1:0]        i_tile_depth,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_tested,
    output logic                                o_now_culled,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import hizq_pkg::*;

    localparam int CW = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
    localparam int RW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int CMD_W = KIND_W + DEPTH_BITS + 2 * RW + 2 * CW;

    t_cfg             r_cfg;
    t_reg_idx         w_idx;
    logic             w_cfg_wr;
    logic             w_cmd_push;
    logic [CMD_W-1:0] w_cmd_wdata;
    logic             w_cmd_full;
    logic             w_cmd_pop;
    logic [CMD_W-1:0] w_cmd_rdata;
    logic             w_cmd_empty;
    logic             w_res_push;
    t_result          w_res_wdata;
    logic             w_res_full;
    t_result          w_res_head;

    // ---------------- configuration registers ----------------
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[PIX_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[PIX_W-1:0];
                REG_FIRST_X:       r_cfg.first_x       <= pwdata[ORG_W-1:0];
                REG_FIRST_Y:       r_cfg.first_y       <= pwdata[ORG_W-1:0];
                REG_LAST_X:        r_cfg.last_x        <= pwdata[ORG_W-1:0];
                REG_LAST_Y:        r_cfg.last_y        <= pwdata[ORG_W-1:0];
                REG_TILE_COLUMNS:  r_cfg.tile_columns  <= pwdata[TCOL_W-1:0];
                REG_TILE_ROWS:     r_cfg.tile_rows     <= pwdata[TROW_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SCREEN_WIDTH:  prdata = 32'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(r_cfg.screen_height);
            REG_FIRST_X:       prdata = 32'(r_cfg.first_x);
            REG_FIRST_Y:       prdata = 32'(r_cfg.first_y);
            REG_LAST_X:        prdata = 32'(r_cfg.last_x);
            REG_LAST_Y:        prdata = 32'(r_cfg.last_y);
            REG_TILE_COLUMNS:  prdata = 32'(r_cfg.tile_columns);
            REG_TILE_ROWS:     prdata = 32'(r_cfg.tile_rows);
            default:           prdata = '0;
        endcase
    end

    // ---------------- front: classify and compute the tile range ----------------
    hizq_front #(
        .TILE_WIDTH      (TILE_WIDTH),
        .TILE_HEIGHT     (TILE_HEIGHT),
        .MAX_TILE_COLUMNS(MAX_TILE_COLUMNS),
        .MAX_TILE_ROWS   (MAX_TILE_ROWS),
        .DEPTH_BITS      (DEPTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_action        (i_action),
        .i_box_min_x     (i_box_min_x),
        .i_box_min_y     (i_box_min_y),
        .i_box_max_x     (i_box_max_x),
        .i_box_max_y     (i_box_max_y),
        .i_nearest_depth (i_nearest_depth),
        .i_already_culled(i_already_culled),
        .i_all_w_positive(i_all_w_positive),
        .i_tile_row      (i_tile_row),
        .i_tile_col      (i_tile_col),
        .i_tile_depth    (i_tile_depth),
        .i_cfg           (r_cfg),
        .o_cmd_push      (w_cmd_push),
        .o_cmd_data      (w_cmd_wdata),
        .i_cmd_full      (w_cmd_full)
    );

    // ---------------- command queue: decouple front from back ----------------
    hizq_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(2)
    ) u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_data (w_cmd_wdata),
        .o_full (w_cmd_full),
        .i_pop  (w_cmd_pop),
        .o_data (w_cmd_rdata),
        .o_empty(w_cmd_empty)
    );

    // ---------------- back: tile store and walk ----------------
    hizq_back #(
        .MAX_TILE_COLUMNS(MAX_TILE_COLUMNS),
        .MAX_TILE_ROWS   (MAX_TILE_ROWS),
        .DEPTH_BITS      (DEPTH_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(w_cmd_empty),
        .i_cmd_data (w_cmd_rdata),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_data (w_res_wdata)
    );

    // ---------------- result queue: hold words until popped ----------------
    hizq_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(2)
    ) u_res_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_wdata),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_head),
        .o_empty(empty)
    );

    assign o_tested     = w_res_head.tested;
    assign o_now_culled = w_res_head.now_culled;

endmodule

// ===== hw/rtl/hizq_checker.sv =====
// Port-level checks of the tile occlusion query, bound to the top level.
// Depends on hiz_tile_occlusion_query.
module hizq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic i_action,
    input logic empty,
    input logic pop,
    input logic o_tested,
    input logic o_now_culled
);

    // the result queue is empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a waiting word holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_tested) && $stable(o_now_culled))
        else $error("waiting result changed or vanished");

    // a skipped query never reports culled
    a_untested_not_culled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_now_culled && !o_tested))
        else $error("culled reported without a test");

    // a query keeps the front busy while it is classified
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full && !i_action |=> full)
        else $error("front took a word while a query was in flight");

endmodule

bind hiz_tile_occlusion_query hizq_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .i_action    (i_action),
    .empty       (empty),
    .pop         (pop),
    .o_tested    (o_tested),
    .o_now_culled(o_now_culled)
);

// ===== tb/hiz_tile_occlusion_query_tb.sv =====
// Testbench for the hierarchical-Z tile occlusion query: loads the tile store, drives
// queries and tile writes under random idling, and checks every result word in order.
// Depends on hizq_pkg and hiz_tile_occlusion_query.
`timescale 1ns / 1ps

module hiz_tile_occlusion_query_tb;
    import hizq_pkg::*;

    // geometry of the instance under test (default parameters)
    localparam int TILE_W    = 32;
    localparam int TILE_H    = 8;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 256;
    localparam int DEPTH_W   = 24;

    // tiles loaded before any query; every query setting keeps its walk inside them
    localparam int LOAD_COLS = 16;
    localparam int LOAD_ROWS = 8;

    // cycles without any accepted word before the run is declared hung; the longest
    // quiet stretches are the receiver hold-off and a walk over every loaded tile
    localparam int STALL_LIMIT   = 4000;
    // let a trailing tile write drain through front and back
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_WORDS   = 225;

    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 24'sh800000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;

    // one input word as the block sees it
    typedef struct {
        logic                        action;
        logic signed [COORD_W-1:0]   min_x;
        logic signed [COORD_W-1:0]   min_y;
        logic signed [COORD_W-1:0]   max_x;
        logic signed [COORD_W-1:0]   max_y;
        logic signed [DEPTH_W-1:0]   nearest;
        logic                        pre_culled;
        logic                        w_positive;
        logic [WROW_W-1:0]           row;
        logic [WCOL_W-1:0]           col;
        logic signed [DEPTH_W-1:0]   depth;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic push = 1'b0;
    logic full;
    logic i_action = 1'b0;
    logic signed [COORD_W-1:0] i_box_min_x = '0;
    logic signed [COORD_W-1:0] i_box_min_y = '0;
    logic signed [COORD_W-1:0] i_box_max_x = '0;
    logic signed [COORD_W-1:0] i_box_max_y = '0;
    logic signed [DEPTH_W-1:0] i_nearest_depth = '0;
    logic i_already_culled = 1'b0;
    logic i_all_w_positive = 1'b0;
    logic [WROW_W-1:0] i_tile_row = '0;
    logic [WCOL_W-1:0] i_tile_col = '0;
    logic signed [DEPTH_W-1:0] i_tile_depth = '0;

    logic empty;
    logic pop = 1'b0;
    logic o_tested;
    logic o_now_culled;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // mirror of the block: tile store and grid registers
    logic signed [DEPTH_W-1:0] tile_depth_copy [GRID_COLS*GRID_ROWS];
    t_cfg grid_cfg = CFG_RESET;

    // verdicts still owed by the block, oldest first
    t_result expected_verdicts[$];
    t_result verdict_seen;
    t_result verdict_want;

    int failures = 0;
    int stall_cycles = 0;

    // idling odds in percent, set per phase by the test sequence
    int tx_idle_pct = 38;
    int rx_idle_pct = 85;

    // long receiver hold-off: the test bumps hold_requests, the receiver counts it out
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    always #4 i_clk = ~i_clk;

    hiz_tile_occlusion_query i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_box_min_x      (i_box_min_x),
        .i_box_min_y      (i_box_min_y),
        .i_box_max_x      (i_box_max_x),
        .i_box_max_y      (i_box_max_y),
        .i_nearest_depth  (i_nearest_depth),
        .i_already_culled (i_already_culled),
        .i_all_w_positive (i_all_w_positive),
        .i_tile_row       (i_tile_row),
        .i_tile_col       (i_tile_col),
        .i_tile_depth     (i_tile_depth),
        .empty            (empty),
        .pop              (pop),
        .o_tested         (o_tested),
        .o_now_culled     (o_now_culled),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    //--------------------------------------------------------------------------
    // Prediction
    //--------------------------------------------------------------------------

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // clamp a pixel coordinate to [0, lim], then drop it to the tile origin below
    function automatic int snap_to_tile(input int p, input int lim, input int tsize);
        int c;
        c = (p < 0) ? 0 : ((p > lim) ? lim : p);
        return c - (c % tsize);
    endfunction

    // tile index range covered by a query box under the current grid registers;
    // start above end means an empty walk
    function automatic void tile_span(input t_word w, output int sx, output int sy,
                                      output int ex, output int ey);
        int mnx, mny, mxx, mxy, cols, rows;
        int fx, fy, lx, ly;
        fx = int'(grid_cfg.first_x);
        fy = int'(grid_cfg.first_y);
        lx = int'(grid_cfg.last_x);
        ly = int'(grid_cfg.last_y);
        mnx = snap_to_tile(int'(w.min_x), int'(grid_cfg.screen_width), TILE_W);
        mny = snap_to_tile(int'(w.min_y), int'(grid_cfg.screen_height), TILE_H);
        mxx = snap_to_tile(int'(w.max_x), int'(grid_cfg.screen_width), TILE_W);
        mxy = snap_to_tile(int'(w.max_y), int'(grid_cfg.screen_height), TILE_H);
        // min corner: raise to first origin, then cap at last; max corner the other way
        mnx = imin(lx, imax(mnx, fx));
        mny = imin(ly, imax(mny, fy));
        mxx = imax(fx, imin(mxx, lx));
        mxy = imax(fy, imin(mxy, ly));
        // tile counts saturate to 1..grid size
        cols = imin(imax(int'(grid_cfg.tile_columns), 1), GRID_COLS);
        rows = imin(imax(int'(grid_cfg.tile_rows), 1), GRID_ROWS);
        sx = imin(cols - 1, mnx / TILE_W);
        sy = imin(rows - 1, mny / TILE_H);
        ex = imin(cols - 1, mxx / TILE_W);
        ey = imin(rows - 1, mxy / TILE_H);
    endfunction

    // visible as soon as one covered tile is farther than the entity's nearest depth
    function automatic t_result predict_verdict(input t_word w);
        t_result v;
        int sx, sy, ex, ey;
        v.tested = 1'b0;
        v.now_culled = 1'b0;
        if (w.pre_culled || !w.w_positive) begin
            return v;
        end
        tile_span(w, sx, sy, ex, ey);
        v.tested = 1'b1;
        v.now_culled = 1'b1;
        for (int y = sy; y <= ey; y++) begin
            for (int x = sx; x <= ex; x++) begin
                if (w.nearest < tile_depth_copy[y*GRID_COLS + x]) begin
                    v.now_culled = 1'b0;
                end
            end
        end
        return v;
    endfunction

    // farthest depth stored under a box; lets the stimulus aim right at the threshold
    function automatic logic signed [DEPTH_W-1:0] span_peak_depth(input t_word w);
        logic signed [DEPTH_W-1:0] peak;
        int sx, sy, ex, ey;
        peak = DEPTH_MIN;
        tile_span(w, sx, sy, ex, ey);
        for (int y = sy; y <= ey; y++) begin
            for (int x = sx; x <= ex; x++) begin
                if (tile_depth_copy[y*GRID_COLS + x] > peak) begin
                    peak = tile_depth_copy[y*GRID_COLS + x];
                end
            end
        end
        return peak;
    endfunction

    //--------------------------------------------------------------------------
    // Word builders
    //--------------------------------------------------------------------------

    // fill every field with noise; the caller sets what matters
    function automatic t_word noise_word();
        t_word w;
        w.action     = ACTION_QUERY;
        w.min_x      = COORD_W'($urandom);
        w.min_y      = COORD_W'($urandom);
        w.max_x      = COORD_W'($urandom);
        w.max_y      = COORD_W'($urandom);
        w.nearest    = DEPTH_W'($urandom);
        w.pre_culled = 1'($urandom_range(1));
        w.w_positive = 1'($urandom_range(1));
        w.row        = WROW_W'($urandom);
        w.col        = WCOL_W'($urandom);
        w.depth      = DEPTH_W'($urandom);
        return w;
    endfunction

    function automatic t_word tile_write_word(input int row, input int col,
                                              input logic signed [DEPTH_W-1:0] depth);
        t_word w;
        w = noise_word();
        w.action = ACTION_WRITE;
        w.row = WROW_W'(row);
        w.col = WCOL_W'(col);
        w.depth = depth;
        return w;
    endfunction

    function automatic logic signed [DEPTH_W-1:0] random_depth();
        case ($urandom_range(9))
            0:       return DEPTH_MIN;
            1:       return DEPTH_MAX;
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    // rewrite tiles inside the loaded area so later queries see the new depths
    function automatic t_word random_write_word();
        return tile_write_word(int'($urandom_range(LOAD_ROWS - 1)),
                               int'($urandom_range(LOAD_COLS - 1)), random_depth());
    endfunction

    function automatic t_word query_word(input int x0, input int y0, input int x1,
                                         input int y1, input logic signed [DEPTH_W-1:0] z);
        t_word w;
        w = noise_word();
        w.action = ACTION_QUERY;
        w.min_x = COORD_W'(x0);
        w.min_y = COORD_W'(y0);
        w.max_x = COORD_W'(x1);
        w.max_y = COORD_W'(y1);
        w.nearest = z;
        w.pre_culled = 1'b0;
        w.w_positive = 1'b1;
        return w;
    endfunction

    // mostly small boxes around the screen with the depth set at or just under the
    // farthest covered tile; a few boxes take random corners from the full coordinate range
    function automatic t_word random_query_word();
        t_word w;
        logic signed [DEPTH_W-1:0] peak;
        int x0, y0, x1, y1, tmp;
        w = noise_word();
        w.action = ACTION_QUERY;
        w.pre_culled = ($urandom_range(99) < 6);
        w.w_positive = ($urandom_range(99) >= 6);
        if ($urandom_range(99) < 4) begin
            // random corners from the full range; the depth stays random as well
            return w;
        end
        x0 = int'($urandom_range(grid_cfg.screen_width + 64)) - 32;
        y0 = int'($urandom_range(grid_cfg.screen_height + 16)) - 8;
        x1 = x0 + int'($urandom_range(80));
        y1 = y0 + int'($urandom_range(24));
        if ($urandom_range(99) < 5) begin
            tmp = x0; x0 = x1 + 40; x1 = tmp;
        end
        w.min_x = COORD_W'(x0);
        w.min_y = COORD_W'(y0);
        w.max_x = COORD_W'(x1);
        w.max_y = COORD_W'(y1);
        peak = span_peak_depth(w);
        case ($urandom_range(2))
            0:       w.nearest = peak;
            1:       w.nearest = (peak == DEPTH_MIN) ? peak : DEPTH_W'(peak - 1);
            default: w.nearest = DEPTH_W'($urandom);
        endcase
        return w;
    endfunction

    //--------------------------------------------------------------------------
    // Input side
    //--------------------------------------------------------------------------

    // offer one word, hold it until accepted, then update the mirror
    task automatic send_word(input t_word w);
        push             <= 1'b1;
        i_action         <= w.action;
        i_box_min_x      <= w.min_x;
        i_box_min_y      <= w.min_y;
        i_box_max_x      <= w.max_x;
        i_box_max_y      <= w.max_y;
        i_nearest_depth  <= w.nearest;
        i_already_culled <= w.pre_culled;
        i_all_w_positive <= w.w_positive;
        i_tile_row       <= w.row;
        i_tile_col       <= w.col;
        i_tile_depth     <= w.depth;
        do @(posedge i_clk); while (full);
        if (w.action == ACTION_WRITE) begin
            tile_depth_copy[int'(w.row)*GRID_COLS + int'(w.col)] = w.depth;
        end else begin
            expected_verdicts.push_back(predict_verdict(w));
        end
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drop push and wait until every owed verdict has come back, then let any
    // trailing tile write settle
    task automatic wait_for_results();
        push <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(input int words, input int write_pct);
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(99) < write_pct) begin
                send_word(random_write_word());
            end else begin
                send_word(random_query_word());
            end
        end
    endtask

    //--------------------------------------------------------------------------
    // Register port
    //--------------------------------------------------------------------------

    // write one register, mirror it, and read it back; call only while idle
    task automatic set_register(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_SCREEN_WIDTH: begin
                grid_cfg.screen_width = value[PIX_W-1:0];
                stored = 32'(grid_cfg.screen_width);
            end
            REG_SCREEN_HEIGHT: begin
                grid_cfg.screen_height = value[PIX_W-1:0];
                stored = 32'(grid_cfg.screen_height);
            end
            REG_FIRST_X: begin
                grid_cfg.first_x = value[ORG_W-1:0];
                stored = 32'(grid_cfg.first_x);
            end
            REG_FIRST_Y: begin
                grid_cfg.first_y = value[ORG_W-1:0];
                stored = 32'(grid_cfg.first_y);
            end
            REG_LAST_X: begin
                grid_cfg.last_x = value[ORG_W-1:0];
                stored = 32'(grid_cfg.last_x);
            end
            REG_LAST_Y: begin
                grid_cfg.last_y = value[ORG_W-1:0];
                stored = 32'(grid_cfg.last_y);
            end
            REG_TILE_COLUMNS: begin
                grid_cfg.tile_columns = value[TCOL_W-1:0];
                stored = 32'(grid_cfg.tile_columns);
            end
            default: begin
                grid_cfg.tile_rows = value[TROW_W-1:0];
                stored = 32'(grid_cfg.tile_rows);
            end
        endcase
        // setup, then access; the register takes the value at the access edge
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        // sample read data mid-access, away from the clock edge
        @(negedge i_clk);
        if (prdata !== stored) begin
            $display("%0t: register %s read expected %0h got %0h",
                     $time, idx.name(), stored, prdata);
            failures++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_grid(input int sw, input int sh, input int fx, input int fy,
                              input int lx, input int ly, input int cols, input int rows);
        set_register(REG_SCREEN_WIDTH, sw);
        set_register(REG_SCREEN_HEIGHT, sh);
        set_register(REG_FIRST_X, fx);
        set_register(REG_FIRST_Y, fy);
        set_register(REG_LAST_X, lx);
        set_register(REG_LAST_Y, ly);
        set_register(REG_TILE_COLUMNS, cols);
        set_register(REG_TILE_ROWS, rows);
    endtask

    // screen, origin range and tile counts fitted to the loaded area
    task automatic apply_base_grid();
        apply_grid(LOAD_COLS * TILE_W, LOAD_ROWS * TILE_H, 0, 0,
                   (LOAD_COLS - 1) * TILE_W, (LOAD_ROWS - 1) * TILE_H,
                   LOAD_COLS, LOAD_ROWS);
    endtask

    //--------------------------------------------------------------------------
    // Result side: check each popped word against the oldest owed verdict
    //--------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            verdict_seen.tested = o_tested;
            verdict_seen.now_culled = o_now_culled;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result word with none owed: tested %0b now_culled %0b",
                         $time, o_tested, o_now_culled);
                failures++;
            end else begin
                verdict_want = expected_verdicts.pop_front();
                if (verdict_seen.tested !== verdict_want.tested) begin
                    $display("%0t: tested expected %0b got %0b",
                             $time, verdict_want.tested, verdict_seen.tested);
                    failures++;
                end
                if (verdict_seen.now_culled !== verdict_want.now_culled) begin
                    $display("%0t: now_culled expected %0b got %0b",
                             $time, verdict_want.now_culled, verdict_seen.now_culled);
                    failures++;
                end
            end
        end
        // pick up a new hold-off request, then count it out before popping again
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        pop <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        if (hold_left > 0) begin
            hold_left--;
        end
    end

    // watchdog: any accepted word on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // the store is not cleared by reset: fit the grid to the loaded area and load
    // every tile in it before any query
    task automatic test_tile_load();
        apply_base_grid();
        for (int r = 0; r < LOAD_ROWS; r++) begin
            for (int c = 0; c < LOAD_COLS; c++) begin
                send_word(tile_write_word(r, c, random_depth()));
            end
        end
        wait_for_results();
    endtask

    task automatic test_directed_queries();
        t_word w;
        // extremes of the tile position and depth
        send_word(tile_write_word(GRID_ROWS - 1, GRID_COLS - 1, DEPTH_MAX));
        send_word(tile_write_word(LOAD_ROWS - 1, LOAD_COLS - 1, DEPTH_MAX));
        send_word(tile_write_word(0, 0, DEPTH_MIN));
        // skipped queries: already culled, W not positive, both
        w = query_word(0, 0, 100, 100, DEPTH_MIN);
        w.pre_culled = 1'b1;
        send_word(w);
        w.pre_culled = 1'b0;
        w.w_positive = 1'b0;
        send_word(w);
        w.pre_culled = 1'b1;
        send_word(w);
        // corners far below zero clamp onto tile (0,0); equal depth is not farther
        send_word(query_word(-32768, -32768, -32768, -32768, DEPTH_MIN));
        // corners far above the screen clamp onto the last tile origin
        send_word(query_word(32767, 32767, 32767, 32767, DEPTH_MAX));
        send_word(query_word(32767, 32767, 32767, 32767, DEPTH_MAX - 24'sd1));
        // full coordinate range: nearest at max walks every tile, at min exits early
        send_word(query_word(-32768, -32768, 32767, 32767, DEPTH_MAX));
        send_word(query_word(-32768, -32768, 32767, 32767, DEPTH_MIN));
        // crossed box: start index beyond end, empty walk, culled
        send_word(query_word(2047, 2047, 0, 0, DEPTH_MIN));
        // boxes straddling a tile boundary and touching the screen edge
        w = query_word(31, 7, 32, 8, '0);
        w.nearest = span_peak_depth(w);
        send_word(w);
        w = query_word(2048, 2048, 2048, 2048, '0);
        w.nearest = DEPTH_W'(span_peak_depth(w) - 1);
        send_word(w);
        wait_for_results();
    endtask

    // every setting keeps the walk inside the loaded tiles
    task automatic test_register_settings();
        // smallest screen: every box collapses to tile (0,0)
        apply_grid(1, 1, 0, 0, 2047, 2047, 64, 256);
        run_traffic(25, 10);
        wait_for_results();
        // widest screen and counts above the grid; origins pinned at the last loaded tile
        apply_grid(4095, 4095, (LOAD_COLS - 1) * TILE_W, (LOAD_ROWS - 1) * TILE_H,
                   (LOAD_COLS - 1) * TILE_W, (LOAD_ROWS - 1) * TILE_H, 127, 511);
        run_traffic(25, 10);
        wait_for_results();
        // crossed origin range on both axes
        apply_grid(2048, 2048, 1000, 1500, 200, 100, LOAD_COLS, LOAD_ROWS);
        run_traffic(25, 10);
        wait_for_results();
        // zero tile counts saturate to one
        apply_grid(1000, 600, 64, 40, 900, 560, 0, 0);
        run_traffic(25, 10);
        wait_for_results();
        // odd counts and a single-tile grid
        apply_grid(777, 333, 0, 0, 2016, 2040, 5, 7);
        run_traffic(25, 10);
        wait_for_results();
        apply_grid(2048, 2048, 0, 0, 0, 0, 1, 1);
        run_traffic(25, 10);
        wait_for_results();
        for (int n = 0; n < 3; n++) begin
            apply_grid($urandom_range(4095), $urandom_range(4095), $urandom_range(2047),
                       $urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                       $urandom_range(LOAD_COLS), $urandom_range(LOAD_ROWS));
            run_traffic(25, 10);
            wait_for_results();
        end
        // back to the loaded-area grid for the random part
        apply_base_grid();
    endtask

    // mixed writes and queries over the three idling phases
    task automatic test_random_traffic();
        tx_idle_pct = 38;
        rx_idle_pct = 85;
        run_traffic(PHASE_WORDS, 15);
        tx_idle_pct = 85;
        rx_idle_pct = 38;
        run_traffic(PHASE_WORDS, 15);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_traffic(PHASE_WORDS, 15);
        wait_for_results();
    endtask

    // hold the result side off while words keep coming so both queues fill and
    // full holds the sender; then pause the sender until everything is back
    task automatic test_result_backpressure();
        hold_requests++;
        run_traffic(40, 0);
        wait_for_results();
        run_traffic(20, 20);
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tile_load();
        test_directed_queries();
        test_register_settings();
        test_random_traffic();
        test_result_backpressure();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hizq_pkg.sv
hw/rtl/hizq_ram.sv
hw/rtl/hizq_fifo.sv
hw/rtl/hizq_front.sv
hw/rtl/hizq_back.sv
hw/rtl/hiz_tile_occlusion_query.sv
hw/rtl/hizq_checker.sv
tb/hiz_tile_occlusion_query_tb.sv
